FILE: rtl/core/assert_macros.svh
// Assertion macros used by the verification files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bps_pkg.sv
package bps_pkg;

  localparam int COORD_W = 16;
  localparam int DATA_W  = 16;
  localparam int COUNT_W = 11;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1000;

  typedef enum logic [1:0] {
    OP_PLACE  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_FIN
  } state_t;

  // One table entry as it is held in memory.
  typedef struct packed {
    logic [DATA_W-1:0]  payload;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } entry_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

FILE: rtl/core/bounded_position_set.sv
// Channel   Direction  Signals                      Contents (lowest bit first)
// s_*       in         s_tvalid s_tready            tdata: pos_x, pos_y, payload
//                      s_tdata s_tuser              tuser: op
// m_*       out        m_tvalid m_tready            tdata: entry_count
//                      m_tdata m_tuser              tuser: status
// cfg_*     in         cfg_wen cfg_wdata            capacity_limit
//
// A place or a remove scans the n stored entries, one memory read per cycle,
// and stops early on a hit; the next request can be taken once its result
// has moved into the output register. A clear skips the scan.
// Reset clears the entry count and sets the limit to 1000, not the memory.
// A finished result waits in the output register, so the next request can be
// taken while the downstream side stalls; only a full register holds it up.
module bounded_position_set #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [15:0] pos_x, [31:16] pos_y, [47:32] payload
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [10:0] entry_count, [15:11] zero
  output logic [2:0]  m_tuser,   // [2:0] status
  input  logic        cfg_wen,
  input  logic [10:0] cfg_wdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [bps_pkg::COUNT_W-1:0] capacity_limit;
  logic                        in_take;
  logic                        in_ready;
  bps_pkg::entry_t             in_item;
  logic                        res_valid;
  logic                        res_ready;
  bps_pkg::res_t               res;
  bps_pkg::res_t               out_res;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  bps_pkg::entry_t             mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  bps_pkg::entry_t             mem_rdata;

  // A transfer on the input side is taken only while the sequencer is idle.
  assign s_tready = in_ready;
  assign in_take  = s_tvalid && s_tready;

  assign in_item.x       = s_tdata[15:0];
  assign in_item.y       = s_tdata[31:16];
  assign in_item.payload = s_tdata[47:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= bps_pkg::LIMIT_RESET;
    end else if (cfg_wen) begin
      capacity_limit <= cfg_wdata;
    end
  end

  // The output register frees itself in the same cycle as its transfer,
  // so a waiting result moves in without a bubble.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'b0, out_res.count};
  assign m_tuser = out_res.status;

  bps_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .in_ready  (in_ready),
    .in_op     (s_tuser),
    .in_item   (in_item),
    .limit     (capacity_limit),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bps_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: rtl/core/bps_mem.sv
module bps_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  bps_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output bps_pkg::entry_t rdata
);

  bps_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/bps_ctrl.sv
module bps_ctrl #(
  parameter int CAPACITY = 1024,
  parameter int AW       = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_take,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  bps_pkg::entry_t             in_item,
  input  logic [bps_pkg::COUNT_W-1:0] limit,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bps_pkg::res_t               res,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output bps_pkg::entry_t             mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  bps_pkg::entry_t             mem_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > bps_pkg::COUNT_W) ? CW : bps_pkg::COUNT_W;

  bps_pkg::state_t  state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    scan_idx, scan_idx_next;
  logic             pend, pend_next;
  logic [AW-1:0]    pend_idx, pend_idx_next;
  logic             found, found_next;
  logic [AW-1:0]    found_idx, found_idx_next;
  logic [1:0]       op, op_next;
  bps_pkg::entry_t  item, item_next;
  bps_pkg::status_t status, status_next;

  logic in_clear;
  logic hit;
  logic scan_end;
  logic at_limit;

  assign in_clear = (in_op != bps_pkg::OP_PLACE) && (in_op != bps_pkg::OP_REMOVE);
  assign hit      = pend && (mem_rdata.x == item.x) && (mem_rdata.y == item.y);
  assign scan_end = (scan_idx == count) && !pend;
  assign at_limit = (LW'(count) >= LW'(limit)) || (LW'(count) >= LW'(CAPACITY));

  assign res.status = status;
  assign res.count  = bps_pkg::COUNT_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bps_pkg::S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx  <= scan_idx_next;
    pend_idx  <= pend_idx_next;
    found_idx <= found_idx_next;
    op        <= op_next;
    item      <= item_next;
    status    <= status_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      bps_pkg::S_IDLE: begin
        if (in_take) begin
          state_next = in_clear ? bps_pkg::S_FIN : bps_pkg::S_SCAN;
        end
      end
      bps_pkg::S_SCAN: begin
        if (hit || scan_end) begin
          state_next = bps_pkg::S_DECIDE;
        end
      end
      bps_pkg::S_DECIDE: begin
        if ((op == bps_pkg::OP_REMOVE) && found) begin
          state_next = bps_pkg::S_MOVE;
        end else begin
          state_next = bps_pkg::S_FIN;
        end
      end
      bps_pkg::S_MOVE: begin
        state_next = bps_pkg::S_FIN;
      end
      bps_pkg::S_FIN: begin
        if (res_ready) begin
          state_next = bps_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bps_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_next     = count;
    scan_idx_next  = scan_idx;
    pend_next      = pend;
    pend_idx_next  = pend_idx;
    found_next     = found;
    found_idx_next = found_idx;
    op_next        = op;
    item_next      = item;
    status_next    = status;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = count[AW-1:0];
    mem_wdata      = item;
    mem_re         = 1'b0;
    mem_raddr      = scan_idx[AW-1:0];
    case (state)
      bps_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_take) begin
          op_next       = in_op;
          item_next     = in_item;
          scan_idx_next = '0;
          pend_next     = 1'b0;
          found_next    = 1'b0;
          if (in_clear) begin
            count_next  = '0;
            status_next = bps_pkg::ST_CLEARED;
          end
        end
      end
      bps_pkg::S_SCAN: begin
        // Reads are issued one per cycle; each comparison uses the data of
        // the read issued in the cycle before.
        if (hit) begin
          found_next     = 1'b1;
          found_idx_next = pend_idx;
          pend_next      = 1'b0;
        end else if (scan_idx != count) begin
          mem_re        = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan_idx[AW-1:0];
          scan_idx_next = scan_idx + CW'(1);
        end else begin
          pend_next = 1'b0;
        end
      end
      bps_pkg::S_DECIDE: begin
        case (op)
          bps_pkg::OP_PLACE: begin
            if (found) begin
              status_next = bps_pkg::ST_DUPLICATE;
            end else if (at_limit) begin
              status_next = bps_pkg::ST_FULL;
            end else begin
              mem_we      = 1'b1;
              count_next  = count + CW'(1);
              status_next = bps_pkg::ST_PLACED;
            end
          end
          default: begin
            if (found) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(count - CW'(1));
            end else begin
              status_next = bps_pkg::ST_NOT_FOUND;
            end
          end
        endcase
      end
      bps_pkg::S_MOVE: begin
        // The last entry fills the slot of the removed one.
        mem_we      = 1'b1;
        mem_waddr   = found_idx;
        mem_wdata   = mem_rdata;
        count_next  = count - CW'(1);
        status_next = bps_pkg::ST_REMOVED;
      end
      bps_pkg::S_FIN: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/bps_checker.sv
`include "assert_macros.svh"

module bps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);

  logic        in_xfer;
  logic        out_stall;
  logic [19:0] out_word;
  logic [10:0] out_count;
  logic        out_cleared;
  logic        out_in_range;

  assign in_xfer      = s_tvalid && s_tready;
  assign out_stall    = m_tvalid && !m_tready;
  assign out_word     = {m_tvalid, m_tuser, m_tdata};
  assign out_count    = m_tdata[10:0];
  assign out_cleared  = m_tvalid && (m_tuser == bps_pkg::ST_CLEARED);
  assign out_in_range = (out_count <= 11'd1024) && (m_tdata[15:11] == 5'd0);

  // No result is offered in the cycle after reset.
  `ASSERT_CLK_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid, "result offered after reset")

  // A stalled result keeps its contents.
  `ASSERT_CLK(a_out_hold, clk, rst, out_stall |=> $stable(out_word), "stalled result changed")

  // Requests are worked on one at a time.
  `ASSERT_CLK(a_one_at_a_time, clk, rst, in_xfer |=> !s_tready, "request taken while busy")

  // A clear always leaves an empty table.
  `ASSERT_CLK(a_clear_empty, clk, rst, out_cleared |-> (out_count == 11'd0), "clear left entries")

  // Every reported count lies within the table and the padding stays zero.
  `ASSERT_CLK(a_count_range, clk, rst, m_tvalid |-> out_in_range, "count out of range")

endmodule

bind bounded_position_set bps_checker u_bps_checker (.*);

FILE: dv/tb_bounded_position_set.sv
module tb_bounded_position_set;

  // Table depth of the instance.
  localparam int CAPACITY = 1024;
  // The fourth opcode is not named in the package. The block treats it as a clear.
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] payload;
  } request_t;

  typedef struct {
    bps_pkg::status_t status;
    logic [10:0]      count;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // [15:0] pos_x, [31:16] pos_y, [47:32] payload
  logic [1:0]  s_tuser = '0;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [10:0] entry_count, [15:11] zero
  logic [2:0]  m_tuser;        // [2:0] status
  logic        cfg_wen = 1'b0;
  logic [10:0] cfg_wdata = '0;

  bounded_position_set #(
    .CAPACITY (CAPACITY)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Requests waiting to be offered, and the outcomes that accepted requests
  // have yet to produce, oldest first.
  request_t request_q[$];
  outcome_t outcome_q[$];
  int       requests_queued = 0;
  int       requests_taken = 0;
  int       mismatch_count = 0;
  // When set, neither side of the stream inserts gaps or stalls.
  bit       quiet = 1'b0;

  // The testbench's own view of the table. Only positions are kept, as the
  // payload never comes back out of the block.
  logic [15:0] slot_x[CAPACITY];
  logic [15:0] slot_y[CAPACITY];
  int          slots_used = 0;
  logic [10:0] limit_model = bps_pkg::LIMIT_RESET;

  // Applies one request to the table model and returns the status and the
  // entry count that the block must report for it.
  function automatic outcome_t table_apply(request_t req);
    outcome_t res;
    int       hit;
    int       lim;
    hit = -1;
    lim = (limit_model > CAPACITY) ? CAPACITY : int'(limit_model);
    if (req.op == bps_pkg::OP_PLACE || req.op == bps_pkg::OP_REMOVE) begin
      for (int i = 0; i < slots_used; i++) begin
        if (hit < 0 && slot_x[i] == req.x && slot_y[i] == req.y) begin
          hit = i;
        end
      end
    end
    if (req.op == bps_pkg::OP_PLACE) begin
      // A stored position wins over a full table.
      if (hit >= 0) begin
        res.status = bps_pkg::ST_DUPLICATE;
      end else if (slots_used >= lim) begin
        res.status = bps_pkg::ST_FULL;
      end else begin
        slot_x[slots_used] = req.x;
        slot_y[slots_used] = req.y;
        slots_used++;
        res.status = bps_pkg::ST_PLACED;
      end
    end else if (req.op == bps_pkg::OP_REMOVE) begin
      if (hit >= 0) begin
        // The last entry fills the hole left by the removed one.
        slot_x[hit] = slot_x[slots_used-1];
        slot_y[hit] = slot_y[slots_used-1];
        slots_used--;
        res.status = bps_pkg::ST_REMOVED;
      end else begin
        res.status = bps_pkg::ST_NOT_FOUND;
      end
    end else begin
      // Both the clear opcode and the spare one empty the table.
      slots_used = 0;
      res.status = bps_pkg::ST_CLEARED;
    end
    res.count = 11'(slots_used);
    return res;
  endfunction

  // Mostly back-to-back, sometimes a short pause and now and then a long one.
  function automatic int next_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (at %0t)", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Source side. The outcome of a request is worked out at the edge on which
  // its transfer takes place, so the model sees requests in the block's order.
  int       src_gap = 0;
  request_t cur_req;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(table_apply(cur_req));
        requests_taken++;
        src_gap = next_gap();
      end
      // A request that is still waiting for tready must stay on the bus.
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {cur_req.payload, cur_req.y, cur_req.x};
          s_tuser <= cur_req.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side. Every result transfer is checked against the oldest outcome
  // that is still awaited, and the receiver stalls at random after a transfer.
  int       sink_gap = 0;
  outcome_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no request awaiting it", int'(m_tuser), -1);
        end else begin
          want = outcome_q.pop_front();
          if (m_tuser !== want.status) begin
            report_mismatch("status", int'(m_tuser), int'(want.status));
          end
          if (m_tdata[10:0] !== want.count) begin
            report_mismatch("entry count", int'(m_tdata[10:0]), int'(want.count));
          end
          if (m_tdata[15:11] !== 5'd0) begin
            report_mismatch("tdata padding", int'(m_tdata[15:11]), 0);
          end
        end
        sink_gap = next_gap();
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic enqueue(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                         input logic [15:0] payload);
    request_t req;
    req.op = op;
    req.x = x;
    req.y = y;
    req.payload = payload;
    request_q.push_back(req);
    requests_queued++;
  endtask

  // Waits until every queued request has been taken and answered. Every
  // request yields exactly one result, so the block is idle afterwards.
  task automatic drain();
    while (requests_taken != requests_queued || outcome_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The limit register is only written while the block is idle, so the model
  // can take the new value straight away.
  task automatic set_limit(input logic [10:0] value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    limit_model = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // A burst of requests clustered on a small patch of the grid, so that
  // duplicates and successful removes are common. One request in ten lands
  // anywhere on the grid.
  task automatic random_phase(input int n);
    logic [15:0] bx;
    logic [15:0] by;
    logic [15:0] x;
    logic [15:0] y;
    logic [1:0]  op;
    int          spread;
    int          r;
    bx = 16'($urandom);
    by = 16'($urandom);
    spread = (1 << $urandom_range(1, 4)) - 1;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 55) op = bps_pkg::OP_PLACE;
      else if (r < 92) op = bps_pkg::OP_REMOVE;
      else if (r < 97) op = bps_pkg::OP_CLEAR;
      else op = OP_SPARE;
      if ($urandom_range(0, 9) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = bx + 16'($urandom_range(0, spread));
        y = by + 16'($urandom_range(0, spread));
      end
      enqueue(op, x, y, 16'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [10:0] limits[8];

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the limit that reset leaves. The corners of the
    // coordinate range, a duplicate, a remove from the middle that pulls the
    // last entry down, removes that miss, and both forms of clear.
    enqueue(bps_pkg::OP_PLACE,  16'h8000, 16'h7fff, 16'h0000);
    enqueue(bps_pkg::OP_PLACE,  16'h7fff, 16'h8000, 16'hffff);
    enqueue(bps_pkg::OP_PLACE,  16'h0000, 16'h0000, 16'h1234);
    enqueue(bps_pkg::OP_PLACE,  16'hffff, 16'hffff, 16'habcd);
    enqueue(bps_pkg::OP_PLACE,  16'h8000, 16'h7fff, 16'h5555);
    enqueue(bps_pkg::OP_PLACE,  16'h7fff, 16'h7fff, 16'haaaa);
    enqueue(bps_pkg::OP_REMOVE, 16'h0000, 16'h0000, 16'h0000);
    enqueue(bps_pkg::OP_REMOVE, 16'h0000, 16'h0000, 16'hffff);
    enqueue(bps_pkg::OP_REMOVE, 16'h8000, 16'h8000, 16'h0000);
    enqueue(bps_pkg::OP_REMOVE, 16'h7fff, 16'h7fff, 16'h0000);
    enqueue(bps_pkg::OP_REMOVE, 16'h8000, 16'h7fff, 16'h0000);
    enqueue(bps_pkg::OP_CLEAR,  16'hffff, 16'hffff, 16'hffff);
    enqueue(bps_pkg::OP_REMOVE, 16'hffff, 16'hffff, 16'h0000);
    enqueue(bps_pkg::OP_PLACE,  16'h0005, 16'h0005, 16'h0001);
    enqueue(OP_SPARE,           16'h0005, 16'h0005, 16'h0001);
    enqueue(bps_pkg::OP_PLACE,  16'h0005, 16'h0005, 16'h0002);
    drain();

    // A zero limit turns every new place away, even into an empty table.
    set_limit(11'd0);
    enqueue(bps_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    enqueue(bps_pkg::OP_PLACE, 16'h0001, 16'h0002, 16'h0003);
    drain();

    // A limit of two: the third place is full, a stored position is still
    // reported as a duplicate.
    set_limit(11'd2);
    enqueue(bps_pkg::OP_PLACE, 16'h0010, 16'h0020, 16'h0001);
    enqueue(bps_pkg::OP_PLACE, 16'h0011, 16'h0020, 16'h0002);
    enqueue(bps_pkg::OP_PLACE, 16'h0012, 16'h0020, 16'h0003);
    enqueue(bps_pkg::OP_PLACE, 16'h0011, 16'h0020, 16'h0004);
    drain();

    // The limit drops below the count: entries stay and places stay full
    // until removes bring the count under the limit again.
    set_limit(11'd1);
    enqueue(bps_pkg::OP_PLACE,  16'h0013, 16'h0020, 16'h0005);
    enqueue(bps_pkg::OP_REMOVE, 16'h0010, 16'h0020, 16'h0000);
    enqueue(bps_pkg::OP_PLACE,  16'h0013, 16'h0020, 16'h0006);
    enqueue(bps_pkg::OP_REMOVE, 16'h0011, 16'h0020, 16'h0000);
    enqueue(bps_pkg::OP_PLACE,  16'h0013, 16'h0020, 16'h0007);
    drain();

    // Random part. Each phase runs under its own limit and starts from
    // whatever the previous phase left in the table.
    limits[0] = bps_pkg::LIMIT_RESET;
    limits[1] = 11'($urandom_range(1, 6));
    limits[2] = 11'h7ff;
    limits[3] = 11'd0;
    limits[4] = 11'($urandom_range(7, 30));
    limits[5] = 11'd1024;
    limits[6] = 11'($urandom_range(1, 3));
    limits[7] = bps_pkg::LIMIT_RESET;
    for (int k = 0; k < 8; k++) begin
      quiet = (k % 3 == 1);
      set_limit(limits[k]);
      random_phase(70);
      drain();
    end

    // Give a stray late result time to show up before the verdict.
    repeat (CAPACITY + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Several times the slowest correct run: every request scanning a full
  // table with the longest gap on both sides.
  initial begin : watchdog
    #100_000_000;
    $display("TIMEOUT waiting for the block");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: bounded_position_set.f
+incdir+rtl/core
rtl/core/bps_pkg.sv
rtl/core/bps_mem.sv
rtl/core/bps_ctrl.sv
rtl/core/bounded_position_set.sv
rtl/core/bps_checker.sv
dv/tb_bounded_position_set.sv
